/* rtl/weighted_round_robin_queue_unit_assert.svh */
// Assertion macros for the weighted round robin queue unit.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef WEIGHTED_ROUND_ROBIN_QUEUE_UNIT_ASSERT_SVH
`define WEIGHTED_ROUND_ROBIN_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRRQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wrrq_pkg.sv */
// Package for the weighted round robin queue unit: payload structs, codes and state type.
// No dependencies.
`default_nettype none

package wrrq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int NUM_WEIGHTS = 4;
  localparam int WIDX_W = 2;
  localparam int WEIGHT_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_PRIO  = 2'd3;

  typedef struct packed {
    logic [1:0]                   action;
    logic signed [DATA_WIDTH-1:0] data_in;
    logic [2:0]                   priority_req;
  } wrrq_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] data_out;
    logic                         data_valid;
    logic [1:0]                   status;
    logic [1:0]                   served_queue;
  } wrrq_out_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } wrrq_fsm_t;

endpackage

`default_nettype wire

/* rtl/weighted_round_robin_queue_unit.sv */
// Weighted round robin queue unit: per-priority FIFOs in one synchronous memory.
// Depends on wrrq_pkg and weighted_round_robin_queue_unit_assert.svh.
//
//   Channel  | Direction | Handshake           | Payload
//   in_      | input     | in_valid / in_stall | wrrq_in_t
//   out_     | output    | out_valid/out_stall | wrrq_out_t
//   cfg_     | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// A push, a no-op or a pop or peek on an empty block is answered in the cycle after it is taken.
// Other pops and peeks pass through rd_data_r before the output register.
// Reset clears pointers, fill levels and the serving state and sets all weights to 1.
// The item memory needs no clearing: only written entries are ever read.
// A result waits in the output register while out_stall is high; input is held off during
// the read cycle of a pop or peek and whenever that register cannot be freed in the same cycle.
`default_nettype none

module weighted_round_robin_queue_unit
  import wrrq_pkg::*;
#(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire wrrq_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output wrrq_out_t                   out_data,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [WEIGHT_W-1:0]    cfg_wdata
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = QW + PW;
  localparam int MEM_DEPTH = NUM_QUEUES << PW;

  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  wrrq_fsm_t state_r, state_nxt;
  logic [PW-1:0] head_r [NUM_QUEUES];
  logic [PW-1:0] head_nxt [NUM_QUEUES];
  logic [PW-1:0] tail_r [NUM_QUEUES];
  logic [PW-1:0] tail_nxt [NUM_QUEUES];
  logic [CW-1:0] fill_r [NUM_QUEUES];
  logic [CW-1:0] fill_nxt [NUM_QUEUES];
  logic [QW-1:0] cur_r, cur_nxt;
  logic [WEIGHT_W-1:0] served_r, served_nxt;
  logic [WEIGHT_W-1:0] weight_r [NUM_WEIGHTS];
  logic [QW-1:0] pend_q_r, pend_q_nxt;
  logic out_valid_r, out_valid_nxt;
  wrrq_out_t out_data_r, out_data_nxt;

  logic mem_we, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic in_acc, out_free;
  logic [NUM_QUEUES-1:0] nonempty;
  logic any_ne;
  logic [QW-1:0] sel, sel_inc, push_q;
  logic [WEIGHT_W-1:0] cnt, cnt_inc;
  logic prio_ok;

  function automatic logic [QW-1:0] next_ne(input logic [QW-1:0] start,
                                            input logic [NUM_QUEUES-1:0] ne);
    logic [QW-1:0] res;
    logic found;
    int idx;
    res = start;
    found = 1'b0;
    for (int k = 0; k < NUM_QUEUES; k++) begin
      idx = int'(start) + k;
      if (idx >= NUM_QUEUES) idx = idx - NUM_QUEUES;
      if (!found && ne[idx]) begin
        res = QW'(idx);
        found = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] q);
    return (q == QW'(NUM_QUEUES - 1)) ? '0 : q + 1'b1;
  endfunction

  function automatic logic [PW-1:0] p_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) nonempty[i] = (fill_r[i] != '0);
  end

  assign any_ne   = |nonempty;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != FSM_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign prio_ok  = (in_data.priority_req != 3'd0) &&
                    (in_data.priority_req <= 3'(NUM_QUEUES));
  assign push_q   = QW'(in_data.priority_req - 3'd1);

  // Settle on the queue to serve: skip an empty one, or rotate once the weight is used.
  always_comb begin
    if (!nonempty[cur_r]) begin
      sel = next_ne(cur_r, nonempty);
      cnt = '0;
    end else if (served_r >= weight_r[WIDX_W'(cur_r)]) begin
      sel = next_ne(q_inc(cur_r), nonempty);
      cnt = '0;
    end else begin
      sel = cur_r;
      cnt = served_r;
    end
  end

  assign sel_inc = q_inc(sel);
  assign cnt_inc = cnt + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    cur_nxt       = cur_r;
    served_nxt    = served_r;
    pend_q_nxt    = pend_q_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    wr_addr       = {push_q, tail_r[push_q]};
    rd_addr       = {sel, head_r[sel]};
    unique case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          out_data_nxt = '0;
          case (in_data.action) inside
            ACT_PUSH: begin
              out_valid_nxt = 1'b1;
              if (!prio_ok) begin
                out_data_nxt.status = ST_BAD_PRIO;
              end else begin
                out_data_nxt.served_queue = 2'(push_q);
                if (fill_r[push_q] == CW'(QUEUE_DEPTH)) begin
                  out_data_nxt.status = ST_FULL;
                end else begin
                  mem_we           = 1'b1;
                  tail_nxt[push_q] = p_inc(tail_r[push_q]);
                  fill_nxt[push_q] = fill_r[push_q] + 1'b1;
                end
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (!any_ne) begin
                out_valid_nxt             = 1'b1;
                out_data_nxt.status       = ST_EMPTY;
                out_data_nxt.served_queue = 2'(cur_r);
              end else begin
                rd_en      = 1'b1;
                pend_q_nxt = sel;
                state_nxt  = FSM_READ;
                if (in_data.action == ACT_POP) begin
                  head_nxt[sel] = p_inc(head_r[sel]);
                  fill_nxt[sel] = fill_r[sel] - 1'b1;
                  if (cnt_inc >= weight_r[WIDX_W'(sel)]) begin
                    cur_nxt    = sel_inc;
                    served_nxt = '0;
                  end else begin
                    cur_nxt    = sel;
                    served_nxt = cnt_inc;
                  end
                end else begin
                  cur_nxt    = sel;
                  served_nxt = cnt;
                end
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      FSM_READ: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.data_out     = rd_data_r;
          out_data_nxt.data_valid   = 1'b1;
          out_data_nxt.status       = ST_OK;
          out_data_nxt.served_queue = 2'(pend_q_r);
          state_nxt                 = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
      cur_r       <= '0;
      served_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      cur_r       <= cur_nxt;
      served_r    <= served_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_q_r   <= pend_q_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) weight_r[i] <= WEIGHT_W'(1);
    end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_WEIGHTS))) begin
      weight_r[WIDX_W'(cfg_index)] <= (cfg_wdata == '0) ? WEIGHT_W'(1) : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= DATA_WIDTH'(in_data.data_in);
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "weighted_round_robin_queue_unit_assert.svh"

  `WRRQ_ASSERT_SAME(a_no_write_during_read, mem_we, !rd_en, "item memory written and read together")
  `WRRQ_ASSERT_NEXT(a_read_enters_wait, rd_en, state_r == FSM_READ && !in_stall == 1'b0, "memory read without wait state")
  `WRRQ_ASSERT_SAME(a_cur_in_range, 1'b1, cur_r <= QW'(NUM_QUEUES - 1), "current queue out of range")

endmodule

`default_nettype wire
